// ===== rtl/idf_pkg.sv =====
package idf_pkg;

	// Input item: one byte for the display controller
	typedef struct packed {
		logic       mode;
		logic [7:0] payload_byte;
		logic       end_of_transfer;
	} in_item_t;

	// Result item: one bus cell
	typedef struct packed {
		logic [1:0] bus_symbol;
		logic       sda_level;
		logic       last_cell;
	} out_item_t;

	// Classified work for the cell sequencer
	typedef struct packed {
		logic       pre_stop;
		logic       header;
		logic       end_mark;
		logic [7:0] addr_byte;
		logic [7:0] ctrl_byte;
		logic [7:0] data_byte;
	} desc_t;

	// Bus cell codes
	localparam logic [1:0] SYM_START = 2'd0;
	localparam logic [1:0] SYM_BIT   = 2'd1;
	localparam logic [1:0] SYM_ACK   = 2'd2;
	localparam logic [1:0] SYM_STOP  = 2'd3;

	// Register indexes
	localparam logic [1:0] CFG_DEVICE_ADDRESS  = 2'd0;
	localparam logic [1:0] CFG_COMMAND_CONTROL = 2'd1;
	localparam logic [1:0] CFG_DATA_CONTROL    = 2'd2;

	// Register reset values
	localparam logic [7:0] RST_DEVICE_ADDRESS  = 8'h78;
	localparam logic [7:0] RST_COMMAND_CONTROL = 8'h00;
	localparam logic [7:0] RST_DATA_CONTROL    = 8'h40;

	// Bit cell count of one byte; the ack cell follows at this count
	localparam logic [3:0] ACK_SLOT = 4'd8;

	// Sequencer phases
	typedef enum logic [5:0] {
		PH_PRESTOP = 6'b000001,
		PH_START   = 6'b000010,
		PH_ADDR    = 6'b000100,
		PH_CTRL    = 6'b001000,
		PH_DATA    = 6'b010000,
		PH_ENDSTOP = 6'b100000
	} phase_t;

endpackage

// ===== rtl/i2c_display_write_framer.sv =====
// Path: a byte beat is written into the descriptor queue, then its cells pass the output register.
// Throughput: one cell per cycle while work is queued and cell_stall is low. A byte is eight bit
// cells and an ack cell; opening adds start, address and control cells; each stop is one cell.
// The front accepts while the descriptor queue has room (QUEUE_DEPTH entries).
// Reset (arst_n low, asynchronous) empties the queue, closes the transfer and loads
// the register defaults: address 0x78, command control 0x00, data control 0x40.
module i2c_display_write_framer
	import idf_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  in_item_t   item,
	output logic       cell_valid,
	input  logic       cell_stall,
	output out_item_t  bus_cell,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic  q_full;
	logic  q_push;
	desc_t q_desc;
	logic  q_pop;
	logic  head_valid;
	desc_t head_desc;

	// Classifier and registers
	idf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_desc     (q_desc)
	);

	// Descriptor queue
	idf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_desc  (q_desc),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	// Cell sequencer
	idf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.pop        (q_pop),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.bus_cell   (bus_cell)
	);

endmodule

// ===== rtl/idf_front.sv =====
module idf_front
	import idf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  in_item_t   item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       q_full,
	output logic       q_push,
	output desc_t      q_desc
);

	logic [7:0] dev_addr_q;
	logic [7:0] cmd_ctrl_q;
	logic [7:0] data_ctrl_q;
	logic       open_q;
	logic       open_mode_q;
	logic       pre_stop;

	assign cfg_ready  = 1'b1;
	assign item_stall = q_full;
	assign q_push     = item_valid && !q_full;

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q  <= RST_DEVICE_ADDRESS;
			cmd_ctrl_q  <= RST_COMMAND_CONTROL;
			data_ctrl_q <= RST_DATA_CONTROL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEVICE_ADDRESS:  dev_addr_q  <= cfg_data;
				CFG_COMMAND_CONTROL: cmd_ctrl_q  <= cfg_data;
				CFG_DATA_CONTROL:    data_ctrl_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Classify against the transfer state as it stands after earlier beats
	always_comb begin
		pre_stop           = open_q && (open_mode_q != item.mode);
		q_desc.pre_stop    = pre_stop;
		q_desc.header      = !open_q || pre_stop;
		q_desc.end_mark    = item.end_of_transfer;
		q_desc.addr_byte   = dev_addr_q;
		q_desc.ctrl_byte   = item.mode ? data_ctrl_q : cmd_ctrl_q;
		q_desc.data_byte   = item.payload_byte;
	end

	// Transfer state moves at accept time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= 1'b0;
			open_mode_q <= 1'b0;
		end else if (q_push) begin
			open_q      <= !item.end_of_transfer;
			open_mode_q <= item.mode;
		end
	end

endmodule

// ===== rtl/idf_queue.sv =====
module idf_queue
	import idf_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output desc_t head_desc
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	desc_t            store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_desc  = store_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_desc;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/idf_back.sv =====
module idf_back
	import idf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  desc_t     head_desc,
	output logic      pop,
	output logic      cell_valid,
	input  logic      cell_stall,
	output out_item_t bus_cell
);

	phase_t     ph_q;
	logic [3:0] bit_q;
	logic       fresh_q;
	out_item_t  cell_q;
	logic       cell_valid_q;

	phase_t     first_ph;
	phase_t     cur_ph;
	phase_t     next_ph;
	logic [3:0] cur_bit;
	logic [3:0] next_bit;
	logic       done;
	logic [7:0] sel_byte;
	out_item_t  cell_d;
	logic       adv;
	logic       emit;

	assign bus_cell   = cell_q;
	assign cell_valid = cell_valid_q;
	assign adv        = !cell_valid_q || !cell_stall;
	assign emit       = adv && head_valid;
	assign pop        = emit && done;

	// Entry phase of a fresh descriptor
	always_comb begin
		priority if (head_desc.pre_stop) begin
			first_ph = PH_PRESTOP;
		end else if (head_desc.header) begin
			first_ph = PH_START;
		end else begin
			first_ph = PH_DATA;
		end
	end

	assign cur_ph  = fresh_q ? first_ph : ph_q;
	assign cur_bit = fresh_q ? '0 : bit_q;

	// Cell generation and phase stepping
	always_comb begin
		next_ph           = cur_ph;
		next_bit          = '0;
		done              = 1'b0;
		sel_byte          = head_desc.data_byte;
		cell_d.bus_symbol = SYM_BIT;
		cell_d.sda_level  = 1'b1;
		unique case (cur_ph)
			PH_PRESTOP: begin
				cell_d.bus_symbol = SYM_STOP;
				next_ph           = PH_START;
			end
			PH_START: begin
				cell_d.bus_symbol = SYM_START;
				next_ph           = PH_ADDR;
			end
			PH_ADDR, PH_CTRL, PH_DATA: begin
				if (cur_ph == PH_ADDR) begin
					sel_byte = head_desc.addr_byte;
				end else if (cur_ph == PH_CTRL) begin
					sel_byte = head_desc.ctrl_byte;
				end
				if (cur_bit == ACK_SLOT) begin
					cell_d.bus_symbol = SYM_ACK;
					if (cur_ph == PH_ADDR) begin
						next_ph = PH_CTRL;
					end else if (cur_ph == PH_CTRL) begin
						next_ph = PH_DATA;
					end else if (head_desc.end_mark) begin
						next_ph = PH_ENDSTOP;
					end else begin
						done = 1'b1;
					end
				end else begin
					cell_d.sda_level = sel_byte[3'd7 - cur_bit[2:0]];
					next_bit         = cur_bit + 1'b1;
				end
			end
			PH_ENDSTOP: begin
				cell_d.bus_symbol = SYM_STOP;
				done              = 1'b1;
			end
			default: begin
				done = 1'b1;
			end
		endcase
		cell_d.last_cell = done;
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= 1'b1;
			ph_q    <= PH_START;
			bit_q   <= '0;
		end else if (emit) begin
			fresh_q <= done;
			ph_q    <= next_ph;
			bit_q   <= next_bit;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_valid_q <= 1'b0;
		end else if (adv) begin
			cell_valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			cell_q <= cell_d;
		end
	end

endmodule
